// ----- rtl/core/acsp_pkg.sv -----
// Shared types and constants for the ANSI CSI sequence parser.
// No dependencies; imported by the parser top level and its checker.
package acsp_pkg;

    // Default width of a collected decimal parameter
    localparam int PARAM_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic CFG_DEFAULT_FG = 1'b0;
    localparam logic CFG_DEFAULT_BG = 1'b1;

    // Event kinds of a result transaction
    localparam logic [2:0] KIND_TEXT   = 3'd0;
    localparam logic [2:0] KIND_ATTR   = 3'd1;
    localparam logic [2:0] KIND_MODES  = 3'd2;
    localparam logic [2:0] KIND_MOVE   = 3'd3;
    localparam logic [2:0] KIND_HOME   = 3'd4;
    localparam logic [2:0] KIND_CLEAR  = 3'd5;
    localparam logic [2:0] KIND_EOL    = 3'd6;
    localparam logic [2:0] KIND_DELETE = 3'd7;

    // Cursor move directions
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    // Byte codes
    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_DIGIT0   = 8'h30;
    localparam logic [7:0] CH_DIGIT9   = 8'h39;
    localparam logic [7:0] CH_FINAL_LO = 8'd64;
    localparam logic [7:0] CH_FINAL_HI = 8'd126;
    localparam logic [7:0] CH_ESC_HI   = 8'd95;
    localparam logic [7:0] CH_SGR      = 8'h6D;  // 'm'
    localparam logic [7:0] CH_MODE_SET = 8'h68;  // 'h'
    localparam logic [7:0] CH_MODE_RST = 8'h6C;  // 'l'
    localparam logic [7:0] CH_UP       = 8'h41;  // 'A'
    localparam logic [7:0] CH_DOWN     = 8'h42;  // 'B'
    localparam logic [7:0] CH_RIGHT    = 8'h43;  // 'C'
    localparam logic [7:0] CH_LEFT     = 8'h44;  // 'D'
    localparam logic [7:0] CH_HOME     = 8'h48;  // 'H'
    localparam logic [7:0] CH_CLEAR    = 8'h4A;  // 'J'
    localparam logic [7:0] CH_EOL      = 8'h4B;  // 'K'
    localparam logic [7:0] CH_DELETE   = 8'h50;  // 'P'

    // SGR parameter codes
    localparam int SGR_RESET     = 0;
    localparam int SGR_BOLD      = 1;
    localparam int SGR_UNDERLINE = 4;
    localparam int SGR_BLINK     = 5;
    localparam int SGR_REVERSE   = 7;
    localparam int SGR_FG_LO     = 30;
    localparam int SGR_FG_HI     = 37;
    localparam int SGR_FG_DEF    = 39;
    localparam int SGR_BG_LO     = 40;
    localparam int SGR_BG_HI     = 47;
    localparam int SGR_BG_DEF    = 49;

    // Mode flag parameters
    localparam int MODE_OVERWRITE = 4;
    localparam int MODE_ECHO      = 12;

    // Reset values of the default colour registers
    localparam logic [2:0] RESET_FG = 3'd7;
    localparam logic [2:0] RESET_BG = 3'd0;

    // Parser phase, one-hot
    typedef enum logic [2:0] {
        PH_TEXT = 3'b001,
        PH_ESC  = 3'b010,
        PH_CSI  = 3'b100
    } phase_t;

    // Display attributes
    typedef struct packed {
        logic [2:0] bg;
        logic [2:0] fg;
        logic       rev;
        logic       blink;
        logic       under;
        logic       bold;
    } attr_t;

    // Terminal modes
    typedef struct packed {
        logic echo;
        logic overwrite;
    } modes_t;

    // One result transaction
    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  text;
        logic [15:0] amount;
        logic [1:0]  dir;
        attr_t       attr;
        modes_t      modes;
    } result_t;

endpackage

// ----- rtl/core/ansi_csi_sequence_parser.sv -----
// ANSI escape / CSI sequence parser, top level.
// Depends on acsp_pkg for types, byte codes and event kinds.

// One byte is taken per clock cycle while in_stall is low; the parser state
// is updated in that same cycle, and a result, if the byte causes one, goes
// to the result register, or to the one skid entry while that register
// still holds one, so bytes keep flowing while a result waits; in_stall
// rises only when both entries hold results that the receiver has not
// taken. The decimal multiply-accumulate and the SGR decode of one parameter
// are the longest paths, both a handful of gates on PARAM_BITS-wide values.
module ansi_csi_sequence_parser #(
    parameter int PARAM_BITS = acsp_pkg::PARAM_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [2:0]  cfg_data,
    // input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_kind,
    output logic [7:0]  text_byte,
    output logic [15:0] amount,
    output logic [1:0]  direction,
    output logic        bold,
    output logic        underline,
    output logic        blink,
    output logic        reverse_video,
    output logic [2:0]  fg_colour,
    output logic [2:0]  bg_colour,
    output logic        overwrite_mode,
    output logic        echo_mode
);
    import acsp_pkg::*;

    localparam int PW   = PARAM_BITS;
    localparam int MW   = PARAM_BITS + 4;
    localparam int WIDE = (PARAM_BITS > 16) ? PARAM_BITS : 17;

    localparam attr_t RESET_ATTR = '{bg: RESET_BG, fg: RESET_FG, default: 1'b0};

    // configuration
    logic [2:0] dfg_reg;
    logic [2:0] dbg_reg;

    // parser state
    phase_t        phase_reg, phase_next;
    logic [PW-1:0] param_reg, param_next;
    logic          has_digit_reg, has_digit_next;
    logic          bad_reg, bad_next;
    logic [PW-1:0] first_reg, first_next;
    logic          have_first_reg, have_first_next;
    attr_t         pending_reg, pending_next;
    modes_t        saw_reg, saw_next;
    attr_t         committed_reg, committed_next;
    modes_t        modes_reg, modes_next;

    // output register and skid entry
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_reg, skid_next;
    logic    skid_valid_reg, skid_valid_next;

    logic    in_fire;
    logic    out_fire;
    logic    emit;
    result_t res;
    logic [2:0]  res_kind;
    logic [7:0]  res_text;
    logic [15:0] res_amount;
    logic [1:0]  res_dir;

    // parameter end helpers
    logic          ep_valid;
    attr_t         sgr_attr;
    modes_t        saw_add;
    attr_t         pending_end;
    modes_t        saw_end;
    logic [PW-1:0] first_end;
    logic [PW-1:0] count_raw;
    logic [WIDE-1:0] count_ext;
    logic [15:0]   count_sat;
    logic [PW-1:0] fg_off;
    logic [MW-1:0] acc;
    logic [7:0]    digit;

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign in_stall = skid_valid_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfg_reg <= RESET_FG;
            dbg_reg <= RESET_BG;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_DEFAULT_FG)
                dfg_reg <= cfg_data;
            else
                dbg_reg <= cfg_data;
        end
    end

    // SGR decode of the parameter being closed
    always_comb
    begin
        sgr_attr = pending_reg;
        fg_off   = param_reg - PW'(SGR_FG_LO);
        if (param_reg == PW'(SGR_RESET))
        begin
            sgr_attr    = '0;
            sgr_attr.fg = dfg_reg;
            sgr_attr.bg = dbg_reg;
        end
        else if (param_reg == PW'(SGR_BOLD))
            sgr_attr.bold = 1'b1;
        else if (param_reg == PW'(SGR_UNDERLINE))
            sgr_attr.under = 1'b1;
        else if (param_reg == PW'(SGR_BLINK))
            sgr_attr.blink = 1'b1;
        else if (param_reg == PW'(SGR_REVERSE))
            sgr_attr.rev = 1'b1;
        else if (param_reg >= PW'(SGR_FG_LO) && param_reg <= PW'(SGR_FG_HI))
            sgr_attr.fg = fg_off[2:0];
        else if (param_reg == PW'(SGR_FG_DEF))
            sgr_attr.fg = dfg_reg;
        else if (param_reg >= PW'(SGR_BG_LO) && param_reg <= PW'(SGR_BG_HI))
            sgr_attr.bg = param_reg[2:0];  // 40 is a multiple of 8
        else if (param_reg == PW'(SGR_BG_DEF))
            sgr_attr.bg = dbg_reg;
    end

    // state as it stands after the current parameter is closed
    always_comb
    begin
        ep_valid          = has_digit_reg && !bad_reg;
        saw_add.overwrite = (param_reg == PW'(MODE_OVERWRITE));
        saw_add.echo      = (param_reg == PW'(MODE_ECHO));
        pending_end       = ep_valid ? sgr_attr : pending_reg;
        saw_end           = ep_valid ? (saw_reg | saw_add) : saw_reg;
        first_end         = (ep_valid && !have_first_reg) ? param_reg : first_reg;
        count_raw         = (have_first_reg || ep_valid) ? first_end : PW'(1);
        count_ext         = WIDE'(count_raw);
        count_sat         = (|count_ext[WIDE-1:16]) ? 16'hFFFF : count_ext[15:0];
    end

    // decimal accumulate with saturation
    always_comb
    begin
        digit = rx_byte - CH_DIGIT0;
        acc   = (MW'(param_reg) << 3) + (MW'(param_reg) << 1) + MW'(digit[3:0]);
    end

    // per-byte parser step
    always_comb
    begin
        phase_next      = phase_reg;
        param_next      = param_reg;
        has_digit_next  = has_digit_reg;
        bad_next        = bad_reg;
        first_next      = first_reg;
        have_first_next = have_first_reg;
        pending_next    = pending_reg;
        saw_next        = saw_reg;
        committed_next  = committed_reg;
        modes_next      = modes_reg;
        emit            = 1'b0;
        res_kind        = KIND_TEXT;
        res_text        = '0;
        res_amount      = '0;
        res_dir         = DIR_UP;

        case (phase_reg)
            PH_ESC:
            begin
                if (rx_byte == CH_LBRACKET)
                begin
                    phase_next      = PH_CSI;
                    param_next      = '0;
                    has_digit_next  = 1'b0;
                    bad_next        = 1'b0;
                    first_next      = '0;
                    have_first_next = 1'b0;
                    saw_next        = '0;
                    pending_next    = committed_reg;
                end
                else
                begin
                    phase_next = PH_TEXT;
                    if (!(rx_byte inside {[CH_FINAL_LO:CH_ESC_HI]}))
                    begin
                        emit     = 1'b1;
                        res_text = rx_byte;
                    end
                end
            end
            PH_CSI:
            begin
                if (rx_byte inside {[CH_DIGIT0:CH_DIGIT9]})
                begin
                    param_next     = (|acc[MW-1:PW]) ? '1 : acc[PW-1:0];
                    has_digit_next = 1'b1;
                end
                else if (rx_byte == CH_SEMI)
                begin
                    pending_next    = pending_end;
                    saw_next        = saw_end;
                    first_next      = first_end;
                    have_first_next = have_first_reg || ep_valid;
                    param_next      = '0;
                    has_digit_next  = 1'b0;
                    bad_next        = 1'b0;
                end
                else if (!(rx_byte inside {[CH_FINAL_LO:CH_FINAL_HI]}))
                    bad_next = 1'b1;
                else
                begin
                    // final byte: close parameter and act
                    pending_next    = pending_end;
                    saw_next        = saw_end;
                    first_next      = first_end;
                    have_first_next = have_first_reg || ep_valid;
                    param_next      = '0;
                    has_digit_next  = 1'b0;
                    bad_next        = 1'b0;
                    phase_next      = PH_TEXT;
                    emit            = 1'b1;
                    case (rx_byte)
                        CH_SGR:
                        begin
                            committed_next = pending_end;
                            res_kind       = KIND_ATTR;
                        end
                        CH_MODE_SET:
                        begin
                            modes_next = modes_reg & ~saw_end;
                            res_kind   = KIND_MODES;
                        end
                        CH_MODE_RST:
                        begin
                            modes_next = modes_reg | saw_end;
                            res_kind   = KIND_MODES;
                        end
                        CH_UP:
                        begin
                            res_kind   = KIND_MOVE;
                            res_amount = count_sat;
                            res_dir    = DIR_UP;
                        end
                        CH_DOWN:
                        begin
                            res_kind   = KIND_MOVE;
                            res_amount = count_sat;
                            res_dir    = DIR_DOWN;
                        end
                        CH_RIGHT:
                        begin
                            res_kind   = KIND_MOVE;
                            res_amount = count_sat;
                            res_dir    = DIR_RIGHT;
                        end
                        CH_LEFT:
                        begin
                            res_kind   = KIND_MOVE;
                            res_amount = count_sat;
                            res_dir    = DIR_LEFT;
                        end
                        CH_HOME:   res_kind = KIND_HOME;
                        CH_CLEAR:  res_kind = KIND_CLEAR;
                        CH_EOL:    res_kind = KIND_EOL;
                        CH_DELETE:
                        begin
                            res_kind   = KIND_DELETE;
                            res_amount = count_sat;
                        end
                        default:   emit = 1'b0;  // unknown final
                    endcase
                end
            end
            default:
            begin
                // plain text
                phase_next = PH_TEXT;
                if (rx_byte == CH_ESC)
                    phase_next = PH_ESC;
                else
                begin
                    emit     = 1'b1;
                    res_text = rx_byte;
                end
            end
        endcase

        res.kind   = res_kind;
        res.text   = res_text;
        res.amount = res_amount;
        res.dir    = res_dir;
        res.attr   = committed_next;
        res.modes  = modes_next;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TEXT;
            param_reg      <= '0;
            has_digit_reg  <= 1'b0;
            bad_reg        <= 1'b0;
            first_reg      <= '0;
            have_first_reg <= 1'b0;
            pending_reg    <= RESET_ATTR;
            saw_reg        <= '0;
            committed_reg  <= RESET_ATTR;
            modes_reg      <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            param_reg      <= param_next;
            has_digit_reg  <= has_digit_next;
            bad_reg        <= bad_next;
            first_reg      <= first_next;
            have_first_reg <= have_first_next;
            pending_reg    <= pending_next;
            saw_reg        <= saw_next;
            committed_reg  <= committed_next;
            modes_reg      <= modes_next;
        end
    end

    // output register and skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // input is stalled; drain skid into the output register
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_fire)
        begin
            out_next       = res;
            out_valid_next = in_fire && emit;
        end
        else if (in_fire && emit)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    // result ports
    assign out_valid      = out_valid_reg;
    assign event_kind     = out_reg.kind;
    assign text_byte      = out_reg.text;
    assign amount         = out_reg.amount;
    assign direction      = out_reg.dir;
    assign bold           = out_reg.attr.bold;
    assign underline      = out_reg.attr.under;
    assign blink          = out_reg.attr.blink;
    assign reverse_video  = out_reg.attr.rev;
    assign fg_colour      = out_reg.attr.fg;
    assign bg_colour      = out_reg.attr.bg;
    assign overwrite_mode = out_reg.modes.overwrite;
    assign echo_mode      = out_reg.modes.echo;

endmodule

// ----- rtl/core/acsp_checker.sv -----
// Port-level checks for the ANSI CSI sequence parser, with its bind.
// Depends on acsp_pkg for event kind codes.
module acsp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  event_kind,
    input logic [7:0]  text_byte,
    input logic [15:0] amount,
    input logic [1:0]  direction
);
    import acsp_pkg::*;

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // input backpressure only when a result is already waiting
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // text byte is zero on control results
    a_text_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_TEXT |-> text_byte == 8'd0)
        else $error("text byte set on control result");

    // amount only for cursor moves and deletes
    a_amount_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_MOVE && event_kind != KIND_DELETE
        |-> amount == 16'd0)
        else $error("amount set on non-count result");

    // direction only for cursor moves
    a_dir_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != KIND_MOVE |-> direction == DIR_UP)
        else $error("direction set on non-move result");

endmodule

bind ansi_csi_sequence_parser acsp_checker u_acsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .text_byte  (text_byte),
    .amount     (amount),
    .direction  (direction)
);
